### rtl/lmfb_pkg.sv
// Shared types, codes and a helper function for the LED matrix frame buffer.
`timescale 1ns / 1ps
`default_nettype none

package lmfb_pkg;

   localparam int unsigned NumRows  = 8;
   localparam int unsigned RowWidth = 8;
   localparam int unsigned CmdWidth = 24;
   localparam int unsigned FrameWidth = NumRows * RowWidth;

   typedef enum logic [2:0] {
      OP_WRITE  = 3'd0,
      OP_TOGGLE = 3'd1,
      OP_FILL   = 3'd2,
      OP_LOAD   = 3'd3,
      OP_SCROLL = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_RIGHT = 2'd3
   } dir_type;

   typedef logic [RowWidth-1:0] row_type;
   typedef logic [NumRows-1:0][RowWidth-1:0] frame_type;

   typedef struct packed {
      logic [2:0] op;
      logic [2:0] col_x;
      logic [2:0] row_y;
      logic [7:0] operand_value;
      logic [7:0] row_data;
      logic [1:0] direction;
   } cmd_type;

   function automatic row_type rot_right8(input row_type v, input logic [2:0] s);
      logic [2*RowWidth-1:0] dbl;
      dbl = {v, v} >> s;
      return dbl[RowWidth-1:0];
   endfunction

endpackage

`default_nettype wire

### rtl/lmfb_cmd_reg.sv
// Input command register with stream handshake toward the request side.
`timescale 1ns / 1ps
`default_nettype none

module lmfb_cmd_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire lmfb_pkg::cmd_type in_cmd,
   input  wire logic             advance,
   output logic                  cmd_valid,
   output lmfb_pkg::cmd_type     cmd
);

   logic              valid_ff, valid_in;
   lmfb_pkg::cmd_type cmd_ff;

   assign in_ready  = !valid_ff || advance;
   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         cmd_ff <= in_cmd;
      end
   end

endmodule

`default_nettype wire

### rtl/lmfb_update.sv
// Next-frame logic: pixel edits, fill, row load and row or column rotation.
`timescale 1ns / 1ps
`default_nettype none

module lmfb_update (
   input  wire lmfb_pkg::frame_type frame_cur,
   input  wire lmfb_pkg::cmd_type   cmd,
   output lmfb_pkg::frame_type      frame_next
);

   lmfb_pkg::row_type   col_mask;
   lmfb_pkg::row_type   row_cur;
   lmfb_pkg::row_type   fill_row;
   lmfb_pkg::frame_type row_scroll;
   lmfb_pkg::frame_type col_scroll;
   logic [2:0]          amt;
   logic [2:0]          neg;
   logic [2:0]          row_shift;
   logic [2:0]          col_shift;

   // Logical column x lives at bit (x-1) mod 8.
   assign col_mask  = lmfb_pkg::rot_right8(lmfb_pkg::row_type'(1) << cmd.col_x, 3'd1);
   assign row_cur   = frame_cur[cmd.row_y];
   assign fill_row  = (cmd.operand_value != 8'd0) ? '1 : '0;
   assign amt       = cmd.operand_value[2:0];
   assign neg       = 3'd0 - amt;
   assign row_shift = (lmfb_pkg::dir_type'(cmd.direction) == lmfb_pkg::DIR_UP) ? amt : neg;
   assign col_shift = (lmfb_pkg::dir_type'(cmd.direction) == lmfb_pkg::DIR_LEFT) ? amt : neg;

   always_comb begin
      for (int j = 0; j < lmfb_pkg::NumRows; j++) begin
         row_scroll[j] = frame_cur[3'(j) + row_shift];
         col_scroll[j] = lmfb_pkg::rot_right8(frame_cur[j], col_shift);
      end
   end

   always_comb begin
      frame_next = frame_cur;
      unique case (cmd.op)
         lmfb_pkg::OP_WRITE: begin
            frame_next[cmd.row_y] = (cmd.operand_value != 8'd0) ? (row_cur | col_mask)
                                                                 : (row_cur & ~col_mask);
         end
         lmfb_pkg::OP_TOGGLE: begin
            frame_next[cmd.row_y] = row_cur ^ col_mask;
         end
         lmfb_pkg::OP_FILL: begin
            frame_next = {lmfb_pkg::NumRows{fill_row}};
         end
         lmfb_pkg::OP_LOAD: begin
            frame_next[cmd.row_y] = lmfb_pkg::rot_right8(cmd.row_data, 3'd1);
         end
         lmfb_pkg::OP_SCROLL: begin
            case (lmfb_pkg::dir_type'(cmd.direction))
               lmfb_pkg::DIR_UP, lmfb_pkg::DIR_DOWN: frame_next = row_scroll;
               default:                              frame_next = col_scroll;
            endcase
         end
         default: begin
            // unused codes leave the frame as is
            frame_next = frame_cur;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/led_matrix_frame_buffer.sv
// Top level of the 8x8 LED matrix frame buffer.
// Usage:
//   Commands arrive on the req_ stream: req_tuser carries the opcode (write
//   pixel, toggle pixel, fill, load row, scroll) and req_tdata the operands.
//   Every accepted command beat produces exactly one rsp_ beat carrying the
//   whole 64-bit frame after that command, row r in bits 8r+7 down to 8r.
//   Path: the command register loads at the accepting edge and the frame
//   and result register when that command advances, which a response stall
//   can hold off; the frame shows on rsp_ once the result register has loaded.
//   Throughput: one command per cycle while rsp_tready stays high; the frame
//   update is a single pass of pixel masks and 8-bit barrel rotators
//   between the command register and the frame register.
//   Reset: synchronous, active high; clears the frame to all dark and
//   empties both stages, so no response is pending afterward.
//   Stall: while rsp_tready is low a pending response holds; the command
//   register still takes one more beat, then req_tready drops until the
//   response is taken.
`timescale 1ns / 1ps
`default_nettype none

module led_matrix_frame_buffer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [lmfb_pkg::CmdWidth-1:0]      req_tdata,  // col_x[2:0], row_y[5:3],
                                                                // operand_value[13:6],
                                                                // row_data[21:14],
                                                                // direction[23:22]
   input  wire logic [2:0]                          req_tuser,  // op[2:0]
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [lmfb_pkg::FrameWidth-1:0]          rsp_tdata   // frame[63:0]
);

   lmfb_pkg::cmd_type   in_cmd;
   lmfb_pkg::cmd_type   cmd;
   logic                cmd_valid;
   logic                advance;
   lmfb_pkg::frame_type frame_ff, frame_in;
   logic                rsp_valid_ff, rsp_valid_in;

   assign in_cmd.op            = req_tuser;
   assign in_cmd.col_x         = req_tdata[2:0];
   assign in_cmd.row_y         = req_tdata[5:3];
   assign in_cmd.operand_value = req_tdata[13:6];
   assign in_cmd.row_data      = req_tdata[21:14];
   assign in_cmd.direction     = req_tdata[23:22];

   // advance the pending command when the result register is free
   assign advance = cmd_valid && (!rsp_valid_ff || rsp_tready);

   lmfb_cmd_reg u_cmd_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (in_cmd),
      .advance   (advance),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   lmfb_update u_update (
      .frame_cur  (frame_ff),
      .cmd        (cmd),
      .frame_next (frame_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         frame_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            frame_ff <= frame_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = frame_ff;

endmodule

`default_nettype wire

### rtl/lmfb_checker.sv
// Port-level checks for the frame buffer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lmfb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [23:0] req_tdata,
   input wire logic [2:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata
);

   // a stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // nothing pending right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // request side only backs up behind a stalled, full response stage
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without a response stall");

   // a beat accepted while no response is pending reaches rsp_ through the command and result registers
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("response missing after command");

endmodule

bind led_matrix_frame_buffer lmfb_checker u_lmfb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
